### design/stida_pkg.sv
// Package for the sorted table with insert, delete and average.
// Holds the sequencer state type, status codes, action codes and fixed field widths.
// No dependencies.
`default_nettype none

package stida_pkg;

  // Fixed widths of the result fields and of the input value
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned AVG_W   = 32;
  localparam int unsigned IN_W    = 32;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_WALK,
    ST_INS_PUT,
    ST_DEL_START,
    ST_DEL_WALK,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN
  } stida_state_e;

endpackage

`default_nettype wire

### design/sorted_table_insert_delete_average.sv
// Sorted table of signed values with insert, delete and a truncated average.
// An item is taken only while in_stall_o is low, and then the block is busy until
// its result sits in the output register. An insert walks down from the top of the
// table, one entry per cycle, moving each entry not less than the value up a place.
// A delete walks the whole table once, one entry per cycle, closing the gap behind
// the match. A restoring divider then forms the average one quotient bit per cycle,
// skipped when the table is empty. The table memory has one write and one registered
// read port and needs no clearing.
`default_nettype none

module sorted_table_insert_delete_average
  import stida_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                action_i,
  input  wire logic [IN_W-1:0]     value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               status_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic signed [AVG_W-1:0]  average_o
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = VALUE_BITS + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  stida_state_e state_q, state_d;

  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic signed [SUM_W-1:0]      sum_q, sum_d;
  logic [AW-1:0]                k_q, k_d;
  logic                         found_q, found_d;
  logic [1:0]                   status_q, status_d;
  logic [CNT_W-1:0]             rem_q, rem_d;
  logic [SUM_W-1:0]             quo_q, quo_d;
  logic                         neg_q, neg_d;
  logic [STEP_W-1:0]            step_q, step_d;

  logic                         out_valid_q, out_valid_d;
  logic [1:0]                   out_status_q, out_status_d;
  logic [COUNT_W-1:0]           out_count_q, out_count_d;
  logic signed [AVG_W-1:0]      out_avg_q, out_avg_d;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [VALUE_BITS-1:0]        ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic signed [VALUE_BITS-1:0] ram_rdata;

  logic                         is_full;
  logic                         is_empty;
  logic                         walk_last;
  logic                         entry_ge;
  logic                         entry_eq;
  logic                         out_free;
  logic [CNT_W:0]               trial;
  logic                         trial_ge;
  logic [SUM_W-1:0]             avg_mag;
  logic signed [VALUE_BITS-1:0] avg_v;

  stida_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign is_full   = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty  = (cnt_q == '0);
  assign walk_last = (CNT_W'(k_q) == cnt_q - CNT_W'(1));
  assign entry_ge  = (ram_rdata >= val_q);
  assign entry_eq  = (ram_rdata == val_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  // One restoring division step: bring down the next dividend bit and try the divisor.
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, cnt_q});

  assign avg_mag = neg_q ? (SUM_W'(0) - quo_q) : quo_q;
  assign avg_v   = avg_mag[VALUE_BITS-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (action_i == ACT_DELETE) ? ST_DEL_START : ST_INS_START;
        end
      end
      ST_INS_START: begin
        if (is_full) begin
          state_d = ST_DIV_INIT;
        end else if (is_empty) begin
          state_d = ST_INS_PUT;
        end else begin
          state_d = ST_INS_WALK;
        end
      end
      ST_INS_WALK: begin
        if (!entry_ge) begin
          state_d = ST_DIV_INIT;
        end else if (k_q == AW'(1)) begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT:   state_d = ST_DIV_INIT;
      ST_DEL_START: state_d = is_empty ? ST_DIV_INIT : ST_DEL_WALK;
      ST_DEL_WALK: begin
        if (walk_last) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT:  state_d = is_empty ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, table access and result register
  always_comb begin
    val_d        = val_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    k_d          = k_q;
    found_d      = found_q;
    status_d     = status_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_avg_d    = out_avg_q;
    ram_we       = 1'b0;
    ram_waddr    = k_q;
    ram_wdata    = val_q;
    ram_raddr    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i[VALUE_BITS-1:0];
          status_d = STATUS_DONE;
          found_d  = 1'b0;
        end
      end
      ST_INS_START: begin
        if (is_full) begin
          status_d = STATUS_FULL;
        end else begin
          k_d       = cnt_q[AW-1:0];
          ram_raddr = AW'(cnt_q - CNT_W'(1));
        end
      end
      ST_INS_WALK: begin
        ram_we = 1'b1;
        if (entry_ge) begin
          // Entry k-1 is not less than the value: move it up one place.
          ram_wdata = ram_rdata;
          k_d       = k_q - AW'(1);
          ram_raddr = k_q - AW'(2);
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
          sum_d = sum_q + SUM_W'(val_q);
        end
      end
      ST_INS_PUT: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
        sum_d  = sum_q + SUM_W'(val_q);
      end
      ST_DEL_START: begin
        if (is_empty) begin
          status_d = STATUS_MISSING;
        end else begin
          k_d = '0;
        end
      end
      ST_DEL_WALK: begin
        // Once the match is passed, every later entry moves down one place.
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = k_q - AW'(1);
          ram_wdata = ram_rdata;
        end else if (entry_eq) begin
          found_d = 1'b1;
        end
        if (!walk_last) begin
          k_d       = k_q + AW'(1);
          ram_raddr = k_q + AW'(1);
        end else if (found_q || entry_eq) begin
          cnt_d = cnt_q - CNT_W'(1);
          sum_d = sum_q - SUM_W'(val_q);
        end else begin
          status_d = STATUS_MISSING;
        end
      end
      ST_DIV_INIT: begin
        rem_d  = '0;
        step_d = STEP_W'(SUM_W);
        if (is_empty) begin
          quo_d = '0;
          neg_d = 1'b0;
        end else begin
          neg_d = sum_q[SUM_W-1];
          quo_d = sum_q[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_q)) : SUM_W'(sum_q);
        end
      end
      ST_DIV: begin
        step_d = step_q - STEP_W'(1);
        if (trial_ge) begin
          rem_d = CNT_W'(trial - {1'b0, cnt_q});
          quo_d = {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial[CNT_W-1:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = COUNT_W'(cnt_q);
          out_avg_d    = AVG_W'(avg_v);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    k_q          <= k_d;
    found_q      <= found_d;
    status_q     <= status_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    neg_q        <= neg_d;
    step_q       <= step_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_avg_q    <= out_avg_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign average_o     = out_avg_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the table capacity.");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("Entry count moved by more than one in a cycle.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Block took an input transfer but did not become busy.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_FULL) |-> entry_count_o == COUNT_W'(CAPACITY))
    else $error("Full status reported with a table that is not full.");
`endif

endmodule

`default_nettype wire

### design/stida_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
`default_nettype none

module stida_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### verif/sorted_table_insert_delete_average_test.sv
`timescale 1ns / 100ps
// Self-checking test for sorted_table_insert_delete_average: drives inserts and deletes,
// predicts status, entry count and truncated average from its own sorted queue and
// checks every result in order. Depends on stida_pkg and the block's RTL.

module sorted_table_insert_delete_average_test;
  import stida_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_WAIT  = 150;

  typedef struct {
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [AVG_W-1:0]  average;
  } table_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     action_i;
  logic [IN_W-1:0]          value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic [COUNT_W-1:0]       entry_count_o;
  logic signed [AVG_W-1:0]  average_o;

  // Predicted contents of the table, in ascending order, and their sum.
  logic signed [IN_W-1:0]   sorted_vals[$];
  longint                   running_total;
  table_result_t            expected_results[$];

  int unsigned error_count;
  int unsigned result_count;
  int unsigned insert_count;
  int unsigned delete_count;
  int unsigned full_count;
  int unsigned missing_count;
  int unsigned stuck_cycles;
  bit          gaps_off;
  bit          long_hold_req;

  sorted_table_insert_delete_average dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .average_o    (average_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic table_result_t predict_table_step(input logic act,
                                                       input logic signed [IN_W-1:0] val);
    table_result_t r;
    int pos;
    r.status = STATUS_DONE;
    pos = 0;
    if (act == ACT_INSERT) begin
      insert_count++;
      if (sorted_vals.size() >= TABLE_DEPTH) begin
        r.status = STATUS_FULL;
        full_count++;
      end else begin
        // An equal value goes in ahead of those already there: stop at the first entry not less.
        while (pos < sorted_vals.size() && sorted_vals[pos] < val) pos++;
        sorted_vals.insert(pos, val);
        running_total += val;
      end
    end else begin
      delete_count++;
      while (pos < sorted_vals.size() && sorted_vals[pos] != val) pos++;
      if (pos >= sorted_vals.size()) begin
        r.status = STATUS_MISSING;
        missing_count++;
      end else begin
        sorted_vals.delete(pos);
        running_total -= val;
      end
    end
    r.entry_count = COUNT_W'(sorted_vals.size());
    if (sorted_vals.size() == 0) r.average = '0;
    else r.average = AVG_W'(running_total / longint'(sorted_vals.size()));
    return r;
  endfunction

  // Values are drawn to give duplicates and the extremes often, wide values otherwise.
  function automatic logic [IN_W-1:0] pick_value();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2, 3, 4: v = $urandom_range(0, 15) - 8;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_item(input logic act, input logic [IN_W-1:0] val);
    int unsigned gap;
    gap = gaps_off ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_table_step(act, val));
  endtask

  task automatic test_directed();
    send_item(ACT_DELETE, 32'd7);           // delete from an empty table
    send_item(ACT_INSERT, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 32'h8000_0000);
    send_item(ACT_INSERT, 32'h8000_0000);   // sum is -2, average truncates to zero
    send_item(ACT_INSERT, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 32'hFFFF_FFF9);   // negative average, truncated toward zero
    send_item(ACT_DELETE, 32'h8000_0000);   // head of the table
    send_item(ACT_DELETE, 32'h7FFF_FFFF);   // tail of the table
    send_item(ACT_DELETE, 32'd42);
    send_item(ACT_INSERT, 32'd3);
    send_item(ACT_INSERT, 32'd3);
    send_item(ACT_INSERT, 32'd3);
    send_item(ACT_DELETE, 32'd3);
    send_item(ACT_DELETE, 32'hFFFF_FFF9);   // entry just above the head
    send_item(ACT_DELETE, 32'hFFFF_FFFF);
    send_item(ACT_DELETE, 32'd3);
    send_item(ACT_DELETE, 32'd3);
    send_item(ACT_DELETE, 32'h7FFF_FFFF);
    send_item(ACT_DELETE, 32'h8000_0000);   // last entry, table empty again
    send_item(ACT_DELETE, 32'h8000_0000);
    send_item(ACT_INSERT, 32'd0);
    send_item(ACT_DELETE, 32'd0);
  endtask

  task automatic test_fill_to_full();
    int n;
    n = TABLE_DEPTH - sorted_vals.size() + 3;
    repeat (n) send_item(ACT_INSERT, pick_value());
  endtask

  task automatic test_random_mix();
    int unsigned insert_pct[6] = '{85, 50, 25, 70, 40, 60};
    logic [IN_W-1:0] v;
    for (int c = 0; c < 6; c++) begin
      gaps_off = (c == 3);
      repeat (100) begin
        if ($urandom_range(1, 100) <= insert_pct[c]) begin
          if (sorted_vals.size() > 0 && $urandom_range(0, 9) < 3)
            v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
          else
            v = pick_value();
          send_item(ACT_INSERT, v);
        end else begin
          if (sorted_vals.size() > 0 && $urandom_range(0, 3) != 0)
            v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
          else
            v = pick_value();
          send_item(ACT_DELETE, v);
        end
      end
    end
    gaps_off = 1'b0;
  endtask

  // The receiver holds off while items keep coming, so the input side must stall.
  // The last transfer must not stay offered while the receiver is waited for.
  task automatic test_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    long_hold_req = 1'b1;
    wait (long_hold_req == 1'b0);
    gaps_off = 1'b1;
    repeat (14) send_item(1'($urandom_range(0, 1)), pick_value());
    gaps_off = 1'b0;
  endtask

  task automatic test_drain();
    while (sorted_vals.size() > 0)
      send_item(ACT_DELETE, sorted_vals[$urandom_range(0, sorted_vals.size() - 1)]);
    send_item(ACT_DELETE, $urandom());
  endtask

  // Result side: random stalls per transfer, one long hold-off on request.
  initial begin
    int unsigned hold;
    table_result_t exp_res;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = gaps_off ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d, entry_count %0d, average %0d",
               status_o, entry_count_o, average_o);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status_o);
          error_count++;
        end
        if (entry_count_o !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_res.entry_count,
                 entry_count_o);
          error_count++;
        end
        if (average_o !== exp_res.average) begin
          $error("average: expected %0d, actual %0d", exp_res.average, average_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog expired: no transfer for %0d cycles", stuck_cycles);
        $display("sorted_table_insert_delete_average_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    error_count   = 0;
    result_count  = 0;
    insert_count  = 0;
    delete_count  = 0;
    full_count    = 0;
    missing_count = 0;
    stuck_cycles  = 0;
    running_total = 0;
    gaps_off      = 1'b0;
    long_hold_req = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= ACT_INSERT;
    value_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_full();
    test_random_mix();
    test_backpressure();
    test_drain();
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d results from %0d inserts and %0d deletes.", result_count,
             insert_count, delete_count);
    $display("Inserts refused on a full table: %0d; deletes of absent values: %0d.",
             full_count, missing_count);
    if (error_count == 0) begin
      $display("sorted_table_insert_delete_average_test OK");
    end else begin
      $display("sorted_table_insert_delete_average_test NOT OK");
    end
    $finish;
  end

endmodule
